/* hdl/hybrid_dimming_waveform_generator_core_assert.svh */
// Assertion macros for the checker file hdwg_chk.sv.
`ifndef HYBRID_DIMMING_WAVEFORM_GENERATOR_CORE_ASSERT_SVH
`define HYBRID_DIMMING_WAVEFORM_GENERATOR_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define HDWG_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("hdwg assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define HDWG_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("hdwg assertion failed");

`endif

/* hdl/hdwg_pkg.sv */
`default_nettype none

package hdwg_pkg;

  localparam int unsigned HALF_SECOND_US = 500000;

  localparam int HALF_W    = 19;
  localparam int FREQ_W    = 8;
  localparam int PWM_W     = 10;
  localparam int TENTH_W   = 4;
  localparam int ENC_W     = 16;
  localparam int CFG_IDX_W = 3;
  localparam int DIV_STEPS = HALF_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  localparam logic [FREQ_W-1:0]  RESET_FREQ_MIN    = 8'd47;
  localparam logic [FREQ_W-1:0]  RESET_FREQ_MAX    = 8'd240;
  localparam logic [PWM_W-1:0]   RESET_PWM_LEVEL   = 10'd767;
  localparam logic [TENTH_W-1:0] RESET_HIGH_TENTHS = 4'd2;
  localparam logic [TENTH_W-1:0] RESET_LOW_TENTHS  = 4'd1;

  localparam logic [HALF_W-1:0] HALF_US    = HALF_W'(HALF_SECOND_US);
  localparam logic [HALF_W-1:0] RESET_HALF = HALF_W'(HALF_SECOND_US / RESET_FREQ_MIN);

  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_POLL = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FREQ_MIN,
    CFG_FREQ_MAX,
    CFG_PWM_LEVEL,
    CFG_HIGH_TENTHS,
    CFG_LOW_TENTHS
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WIN,
    ST_ENC,
    ST_DIV,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic              start;
    logic [FREQ_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [HALF_W-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

/* hdl/hdwg_div.sv */
`default_nettype none

module hdwg_div (
  input  wire               clk,
  input  wire               rst_n,
  input  hdwg_pkg::div_req_t req,
  output hdwg_pkg::div_rsp_t rsp
);

  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic [hdwg_pkg::CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [hdwg_pkg::FREQ_W-1:0]   dvs_r;
  logic [hdwg_pkg::HALF_W-1:0]   dvd_r;
  logic [hdwg_pkg::HALF_W-1:0]   q_r;
  logic [hdwg_pkg::FREQ_W-1:0]   rem_r;

  logic [hdwg_pkg::FREQ_W:0]     rem_sh;
  logic [hdwg_pkg::FREQ_W:0]     diff;
  logic                          ge;
  logic [hdwg_pkg::FREQ_W-1:0]   rem_step;

  assign rem_sh   = {rem_r, dvd_r[hdwg_pkg::HALF_W-1]};
  assign ge       = rem_sh >= {1'b0, dvs_r};
  assign diff     = rem_sh - {1'b0, dvs_r};
  assign rem_step = ge ? diff[hdwg_pkg::FREQ_W-1:0] : rem_sh[hdwg_pkg::FREQ_W-1:0];

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
    end else if (busy_r) begin
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == hdwg_pkg::CNT_W'(hdwg_pkg::DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvs_r <= req.divisor;
      dvd_r <= hdwg_pkg::HALF_US;
      rem_r <= '0;
      q_r   <= '0;
    end else if (busy_r) begin
      dvd_r <= dvd_r << 1;
      rem_r <= rem_step;
      q_r   <= {q_r[hdwg_pkg::HALF_W-2:0], ge};
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = q_r;

endmodule

`default_nettype wire

/* hdl/hdwg_win.sv */
`default_nettype none

module hdwg_win (
  input  wire                          level,
  input  wire [hdwg_pkg::HALF_W-1:0]   tick_count,
  input  wire [hdwg_pkg::HALF_W-1:0]   half_ticks,
  input  wire [hdwg_pkg::TENTH_W-1:0]  high_tenths,
  input  wire [hdwg_pkg::TENTH_W-1:0]  low_tenths,
  output logic                         in_window
);

  localparam int W = hdwg_pkg::HALF_W + hdwg_pkg::TENTH_W;

  logic [hdwg_pkg::HALF_W-1:0]  remaining;
  logic [hdwg_pkg::TENTH_W-1:0] tenths;
  logic [W-1:0]                 rem_x10;
  logic [W-1:0]                 limit;

  assign remaining = half_ticks - tick_count;
  assign tenths    = level ? high_tenths : low_tenths;
  assign rem_x10   = (W'(remaining) << 3) + (W'(remaining) << 1);
  assign limit     = W'(half_ticks) * W'(tenths);
  assign in_window = rem_x10 < limit;

endmodule

`default_nettype wire

/* hdl/hybrid_dimming_waveform_generator_core.sv */
// Tick beat: accepted in IDLE, then WIN and OUT; the result loads in OUT and the
// block returns to IDLE for another beat. Poll beat: IDLE, ENC and OUT, or IDLE, ENC,
// DIV and OUT when the encoder level moves to a non-zero frequency and the half period
// is rebuilt by the 19-step restoring divider (one quotient bit a cycle). One beat in
// flight at a time; a stalled result beat holds the block in OUT.
// Synchronous active-low reset: registers to defaults, 47 Hz, half period 10638 ticks.
`default_nettype none

module hybrid_dimming_waveform_generator_core #(
  parameter int DUTY_BITS = 10
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire                          in_kind,
  input  wire signed [7:0]             in_encoder_delta,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic                         out_square_level,
  output logic [hdwg_pkg::PWM_W-1:0]   out_pwm_duty,
  output logic [hdwg_pkg::FREQ_W-1:0]  out_frequency,
  output logic [hdwg_pkg::HALF_W-1:0]  out_half_period,
  input  wire                          cfg_wr_en,
  input  wire [hdwg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire [hdwg_pkg::PWM_W-1:0]    cfg_data
);

  localparam int DUTY_W = (DUTY_BITS < hdwg_pkg::PWM_W) ? DUTY_BITS : hdwg_pkg::PWM_W;
  localparam logic [hdwg_pkg::PWM_W-1:0] DUTY_MASK = ~({hdwg_pkg::PWM_W{1'b1}} << DUTY_W);

  hdwg_pkg::state_t state_r, state_nxt;

  logic [hdwg_pkg::FREQ_W-1:0]  freq_min_r, freq_min_nxt;
  logic [hdwg_pkg::FREQ_W-1:0]  freq_max_r, freq_max_nxt;
  logic [hdwg_pkg::PWM_W-1:0]   pwm_level_r, pwm_level_nxt;
  logic [hdwg_pkg::TENTH_W-1:0] hi_tenths_r, hi_tenths_nxt;
  logic [hdwg_pkg::TENTH_W-1:0] lo_tenths_r, lo_tenths_nxt;

  logic [hdwg_pkg::HALF_W-1:0]  tick_count_r, tick_count_nxt;
  logic                         level_r, level_nxt;
  logic                         pwm_active_r, pwm_active_nxt;
  logic [hdwg_pkg::FREQ_W-1:0]  freq_now_r, freq_now_nxt;
  logic [hdwg_pkg::HALF_W-1:0]  half_ticks_r, half_ticks_nxt;
  logic [hdwg_pkg::ENC_W-1:0]   enc_sum_r, enc_sum_nxt;
  logic [hdwg_pkg::ENC_W-1:0]   enc_last_r, enc_last_nxt;

  logic                         out_valid_r, out_valid_nxt;
  logic                         out_level_r;
  logic [hdwg_pkg::PWM_W-1:0]   out_duty_r;
  logic [hdwg_pkg::FREQ_W-1:0]  out_freq_r;
  logic [hdwg_pkg::HALF_W-1:0]  out_half_r;

  logic                         in_acc;
  logic                         out_load;
  logic                         in_window;
  logic [hdwg_pkg::HALF_W-1:0]  tick_inc;

  logic [hdwg_pkg::ENC_W-1:0]   sum_adj;
  logic signed [hdwg_pkg::ENC_W-1:0] half_sum;
  logic                         step_up, step_dn, changed;
  logic [hdwg_pkg::FREQ_W:0]    freq_up9;
  logic [hdwg_pkg::FREQ_W-1:0]  freq_up, freq_dn, freq_new;
  logic [hdwg_pkg::FREQ_W-1:0]  freq_m1;

  hdwg_pkg::div_req_t div_req;
  hdwg_pkg::div_rsp_t div_rsp;

  hdwg_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  hdwg_win u_win (
    .level       (level_r),
    .tick_count  (tick_count_r),
    .half_ticks  (half_ticks_r),
    .high_tenths (hi_tenths_r),
    .low_tenths  (lo_tenths_r),
    .in_window   (in_window)
  );

  assign in_acc   = in_valid && in_ready;
  assign tick_inc = tick_count_r + 1'b1;

  assign sum_adj  = enc_sum_r + hdwg_pkg::ENC_W'(enc_sum_r[hdwg_pkg::ENC_W-1]);
  assign half_sum = $signed(sum_adj) >>> 1;
  assign step_up  = half_sum > $signed(enc_last_r);
  assign step_dn  = half_sum < $signed(enc_last_r);
  assign changed  = step_up || step_dn;

  assign freq_up9 = {1'b0, freq_now_r} + 1'b1;
  assign freq_up  = (freq_up9 > {1'b0, freq_max_r}) ? freq_max_r
                                                    : freq_up9[hdwg_pkg::FREQ_W-1:0];
  assign freq_m1  = freq_now_r - 1'b1;
  assign freq_dn  = (freq_now_r == '0 || freq_m1 < freq_min_r) ? freq_min_r : freq_m1;
  assign freq_new = step_up ? freq_up : freq_dn;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      hdwg_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_kind == hdwg_pkg::KIND_POLL) ? hdwg_pkg::ST_ENC : hdwg_pkg::ST_WIN;
        end
      end
      hdwg_pkg::ST_WIN: state_nxt = hdwg_pkg::ST_OUT;
      hdwg_pkg::ST_ENC: begin
        state_nxt = (changed && freq_new != '0) ? hdwg_pkg::ST_DIV : hdwg_pkg::ST_OUT;
      end
      hdwg_pkg::ST_DIV: begin
        if (div_rsp.done) begin
          state_nxt = hdwg_pkg::ST_OUT;
        end
      end
      hdwg_pkg::ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = hdwg_pkg::ST_IDLE;
        end
      end
      default: state_nxt = hdwg_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready        = (state_r == hdwg_pkg::ST_IDLE);
    div_req.start   = (state_r == hdwg_pkg::ST_ENC) && changed && (freq_new != '0);
    div_req.divisor = freq_new;
    out_load        = (state_r == hdwg_pkg::ST_OUT) && (!out_valid_r || out_ready);
  end

  always_comb begin
    freq_min_nxt   = freq_min_r;
    freq_max_nxt   = freq_max_r;
    pwm_level_nxt  = pwm_level_r;
    hi_tenths_nxt  = hi_tenths_r;
    lo_tenths_nxt  = lo_tenths_r;
    tick_count_nxt = tick_count_r;
    level_nxt      = level_r;
    pwm_active_nxt = pwm_active_r;
    freq_now_nxt   = freq_now_r;
    half_ticks_nxt = half_ticks_r;
    enc_sum_nxt    = enc_sum_r;
    enc_last_nxt   = enc_last_r;

    if (cfg_wr_en) begin
      unique case (cfg_index)
        hdwg_pkg::CFG_FREQ_MIN:    freq_min_nxt  = cfg_data[hdwg_pkg::FREQ_W-1:0];
        hdwg_pkg::CFG_FREQ_MAX:    freq_max_nxt  = cfg_data[hdwg_pkg::FREQ_W-1:0];
        hdwg_pkg::CFG_PWM_LEVEL:   pwm_level_nxt = cfg_data & DUTY_MASK;
        hdwg_pkg::CFG_HIGH_TENTHS: hi_tenths_nxt = cfg_data[hdwg_pkg::TENTH_W-1:0];
        hdwg_pkg::CFG_LOW_TENTHS:  lo_tenths_nxt = cfg_data[hdwg_pkg::TENTH_W-1:0];
        default: ;
      endcase
    end

    if (in_acc) begin
      if (in_kind == hdwg_pkg::KIND_TICK) begin
        if (tick_inc >= half_ticks_r) begin
          level_nxt      = ~level_r;
          tick_count_nxt = '0;
        end else begin
          tick_count_nxt = tick_inc;
        end
      end else begin
        enc_sum_nxt = enc_sum_r + hdwg_pkg::ENC_W'(in_encoder_delta);
      end
    end

    if (state_r == hdwg_pkg::ST_WIN) begin
      if (level_r) begin
        pwm_active_nxt = pwm_active_r || in_window;
      end else begin
        pwm_active_nxt = in_window;
      end
    end

    if (state_r == hdwg_pkg::ST_ENC && changed) begin
      enc_last_nxt = half_sum;
      freq_now_nxt = freq_new;
      if (freq_new == '0) begin
        half_ticks_nxt = hdwg_pkg::HALF_US;
      end
    end

    if (state_r == hdwg_pkg::ST_DIV && div_rsp.done) begin
      half_ticks_nxt = div_rsp.quotient;
    end
  end

  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= hdwg_pkg::ST_IDLE;
      freq_min_r   <= hdwg_pkg::RESET_FREQ_MIN;
      freq_max_r   <= hdwg_pkg::RESET_FREQ_MAX;
      pwm_level_r  <= hdwg_pkg::RESET_PWM_LEVEL & DUTY_MASK;
      hi_tenths_r  <= hdwg_pkg::RESET_HIGH_TENTHS;
      lo_tenths_r  <= hdwg_pkg::RESET_LOW_TENTHS;
      tick_count_r <= '0;
      level_r      <= 1'b0;
      pwm_active_r <= 1'b0;
      freq_now_r   <= hdwg_pkg::RESET_FREQ_MIN;
      half_ticks_r <= hdwg_pkg::RESET_HALF;
      enc_sum_r    <= '0;
      enc_last_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      freq_min_r   <= freq_min_nxt;
      freq_max_r   <= freq_max_nxt;
      pwm_level_r  <= pwm_level_nxt;
      hi_tenths_r  <= hi_tenths_nxt;
      lo_tenths_r  <= lo_tenths_nxt;
      tick_count_r <= tick_count_nxt;
      level_r      <= level_nxt;
      pwm_active_r <= pwm_active_nxt;
      freq_now_r   <= freq_now_nxt;
      half_ticks_r <= half_ticks_nxt;
      enc_sum_r    <= enc_sum_nxt;
      enc_last_r   <= enc_last_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_level_r <= level_r;
      out_duty_r  <= pwm_active_r ? pwm_level_r : '0;
      out_freq_r  <= freq_now_r;
      out_half_r  <= half_ticks_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_square_level = out_level_r;
  assign out_pwm_duty     = out_duty_r;
  assign out_frequency    = out_freq_r;
  assign out_half_period  = out_half_r;

endmodule

`default_nettype wire

/* hdl/hdwg_chk.sv */
`default_nettype none
`include "hybrid_dimming_waveform_generator_core_assert.svh"

module hdwg_chk (
  input wire                          clk,
  input wire                          rst_n,
  input wire                          in_valid,
  input wire                          in_ready,
  input wire                          out_valid,
  input wire                          out_ready,
  input wire                          out_square_level,
  input wire [hdwg_pkg::PWM_W-1:0]    out_pwm_duty,
  input wire [hdwg_pkg::FREQ_W-1:0]   out_frequency,
  input wire [hdwg_pkg::HALF_W-1:0]   out_half_period
);

  // hold a stalled result beat
  `HDWG_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_square_level) && $stable(out_pwm_duty) && $stable(out_frequency) && $stable(out_half_period))

  `HDWG_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)

  `HDWG_ASSERT_NOW(a_half_nonzero, clk, rst_n, out_valid, out_half_period != '0)

  `HDWG_ASSERT_NOW(a_one_hz_half, clk, rst_n, out_valid && out_frequency == 8'd1, out_half_period == hdwg_pkg::HALF_US)

endmodule

bind hybrid_dimming_waveform_generator_core hdwg_chk u_hdwg_chk (.*);

`default_nettype wire

/* bench/hdwg_waveform_check.sv */
module hdwg_waveform_check
  import hdwg_pkg::*;
(
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  input  wire                 in_ready,
  input  wire                 in_kind,
  input  wire signed [7:0]    in_encoder_delta,
  input  wire                 out_valid,
  input  wire                 out_ready,
  input  wire                 out_square_level,
  input  wire [PWM_W-1:0]     out_pwm_duty,
  input  wire [FREQ_W-1:0]    out_frequency,
  input  wire [HALF_W-1:0]    out_half_period,
  input  wire                 cfg_wr_en,
  input  wire [CFG_IDX_W-1:0] cfg_index,
  input  wire [PWM_W-1:0]     cfg_data,
  output int                  mismatch_count,
  output int                  waiting_beats
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic              square;
    logic [PWM_W-1:0]  duty;
    logic [FREQ_W-1:0] freq;
    logic [HALF_W-1:0] half;
  } waveform_t;

  waveform_t expected_waveform[$];
  waveform_t head;

  logic [FREQ_W-1:0]  lim_lo;
  logic [FREQ_W-1:0]  lim_hi;
  logic [PWM_W-1:0]   duty_lvl;
  logic [TENTH_W-1:0] hi_tenths;
  logic [TENTH_W-1:0] lo_tenths;

  logic [HALF_W-1:0]       tick_cnt;
  logic                    sq;
  logic                    pwm_on;
  logic [FREQ_W-1:0]       freq;
  logic [HALF_W-1:0]       half;
  logic signed [ENC_W-1:0] enc_sum;
  logic signed [ENC_W-1:0] enc_last;

  initial mismatch_count = 0;
  initial waiting_beats = 0;

  function automatic logic [HALF_W-1:0] half_for(input logic [FREQ_W-1:0] f);
    if (f == '0) begin
      return HALF_US;
    end
    return HALF_W'(HALF_SECOND_US / f);
  endfunction

  task automatic advance_waveform(input logic kind, input logic signed [7:0] delta);
    int unsigned left;
    int          halved;
    int          f;
    bit          stepped;
    waveform_t   w;
    stepped = 1'b0;
    if (kind == KIND_TICK) begin
      tick_cnt = tick_cnt + 1'b1;
      if (tick_cnt >= half) begin
        sq = ~sq;
        tick_cnt = '0;
      end
      left = 32'(half) - 32'(tick_cnt);
      if (sq) begin
        if (left * 32'd10 < 32'(half) * 32'(hi_tenths)) pwm_on = 1'b1;
      end else begin
        pwm_on = (left * 32'd10 < 32'(half) * 32'(lo_tenths));
      end
    end else begin
      enc_sum = enc_sum + {{8{delta[7]}}, delta};
      halved = int'(enc_sum) / 2;
      f = int'(freq);
      if (halved > int'(enc_last)) begin
        enc_last = ENC_W'(halved);
        f = f + 1;
        if (f > int'(lim_hi)) f = int'(lim_hi);
        stepped = 1'b1;
      end else if (halved < int'(enc_last)) begin
        enc_last = ENC_W'(halved);
        f = f - 1;
        if (f < int'(lim_lo)) f = int'(lim_lo);
        stepped = 1'b1;
      end
      if (stepped) begin
        if (f < 0) f = 0;
        freq = FREQ_W'(f);
        half = half_for(freq);
      end
    end
    w.square = sq;
    w.duty   = pwm_on ? duty_lvl : '0;
    w.freq   = freq;
    w.half   = half;
    expected_waveform.push_back(w);
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      lim_lo    = RESET_FREQ_MIN;
      lim_hi    = RESET_FREQ_MAX;
      duty_lvl  = RESET_PWM_LEVEL;
      hi_tenths = RESET_HIGH_TENTHS;
      lo_tenths = RESET_LOW_TENTHS;
      tick_cnt  = '0;
      sq        = 1'b0;
      pwm_on    = 1'b0;
      freq      = RESET_FREQ_MIN;
      half      = half_for(RESET_FREQ_MIN);
      enc_sum   = '0;
      enc_last  = '0;
      expected_waveform.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_FREQ_MIN:    lim_lo    = cfg_data[FREQ_W-1:0];
          CFG_FREQ_MAX:    lim_hi    = cfg_data[FREQ_W-1:0];
          CFG_PWM_LEVEL:   duty_lvl  = cfg_data;
          CFG_HIGH_TENTHS: hi_tenths = cfg_data[TENTH_W-1:0];
          CFG_LOW_TENTHS:  lo_tenths = cfg_data[TENTH_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_waveform.size() == 0) begin
          mismatch_count++;
          $display("%0t: result beat with nothing expected, actual level %0d duty %0d freq %0d half %0d",
                   $time, out_square_level, out_pwm_duty, out_frequency, out_half_period);
        end else begin
          head = expected_waveform.pop_front();
          compare_field("square_level", 32'(head.square), 32'(out_square_level));
          compare_field("pwm_duty", 32'(head.duty), 32'(out_pwm_duty));
          compare_field("frequency", 32'(head.freq), 32'(out_frequency));
          compare_field("half_period", 32'(head.half), 32'(out_half_period));
        end
      end
      if (in_valid && in_ready) advance_waveform(in_kind, in_encoder_delta);
    end
    waiting_beats <= expected_waveform.size();
  end

endmodule

/* bench/hybrid_dimming_waveform_generator_core_tb.sv */
module hybrid_dimming_waveform_generator_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hdwg_pkg::*;

  typedef enum {SEND_SLOW, RECV_SLOW, NO_GAPS} pacing_t;

  logic                   clk;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_kind = KIND_TICK;
  logic signed [7:0]      in_encoder_delta = '0;
  logic                   out_ready = 1'b0;
  logic                   cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [PWM_W-1:0]       cfg_data = '0;
  wire                    in_ready;
  wire                    out_valid;
  wire                    out_square_level;
  wire [PWM_W-1:0]        out_pwm_duty;
  wire [FREQ_W-1:0]       out_frequency;
  wire [HALF_W-1:0]       out_half_period;

  int send_gap = 0;
  int recv_gap = 0;
  int mismatch_count;
  int waiting_beats;

  hybrid_dimming_waveform_generator_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_kind          (in_kind),
    .in_encoder_delta (in_encoder_delta),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_square_level (out_square_level),
    .out_pwm_duty     (out_pwm_duty),
    .out_frequency    (out_frequency),
    .out_half_period  (out_half_period),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  hdwg_waveform_check watch (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_kind          (in_kind),
    .in_encoder_delta (in_encoder_delta),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_square_level (out_square_level),
    .out_pwm_duty     (out_pwm_duty),
    .out_frequency    (out_frequency),
    .out_half_period  (out_half_period),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .mismatch_count   (mismatch_count),
    .waiting_beats    (waiting_beats)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_gap);
  end

  task automatic set_pacing(input pacing_t p);
    case (p)
      SEND_SLOW: begin
        send_gap = 28;
        recv_gap = 54;
      end
      RECV_SLOW: begin
        send_gap = 54;
        recv_gap = 28;
      end
      default: begin
        send_gap = 0;
        recv_gap = 0;
      end
    endcase
  endtask

  // hold valid and payload until the beat is taken
  task automatic send_beat(input logic k, input logic signed [7:0] d);
    while ($urandom_range(99) < send_gap) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_kind          <= k;
    in_encoder_delta <= d;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (waiting_beats != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [PWM_W-1:0] v);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
  endtask

  task automatic random_beats(input int beats, input int poll_pct, input bit pull_down);
    logic              k;
    logic signed [7:0] d;
    int                r;
    repeat (beats) begin
      k = ($urandom_range(99) < poll_pct) ? KIND_POLL : KIND_TICK;
      r = $urandom_range(9);
      if (pull_down && k == KIND_POLL && r < 7) begin
        d = 8'sh80;
      end else if (r < 4) begin
        d = 8'($urandom_range(6)) - 8'd3;
      end else begin
        d = 8'($urandom);
      end
      send_beat(k, d);
    end
  endtask

  task automatic run_segment(input pacing_t p, input logic [7:0] f_lo, input logic [7:0] f_hi,
                             input logic [PWM_W-1:0] duty, input logic [3:0] hi_t,
                             input logic [3:0] lo_t, input int beats, input int poll_pct,
                             input bit pull_down);
    settle();
    write_reg(CFG_FREQ_MIN, PWM_W'(f_lo));
    write_reg(CFG_FREQ_MAX, PWM_W'(f_hi));
    write_reg(CFG_PWM_LEVEL, duty);
    write_reg(CFG_HIGH_TENTHS, PWM_W'(hi_t));
    write_reg(CFG_LOW_TENTHS, PWM_W'(lo_t));
    cfg_wr_en <= 1'b0;
    set_pacing(p);
    random_beats(beats, poll_pct, pull_down);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    set_pacing(SEND_SLOW);

    send_beat(KIND_TICK, 8'sh00);
    send_beat(KIND_TICK, 8'sh7f);
    send_beat(KIND_TICK, 8'sh80);
    send_beat(KIND_POLL, 8'sh01);
    send_beat(KIND_POLL, 8'sh01);
    send_beat(KIND_POLL, 8'sh00);
    send_beat(KIND_POLL, 8'sh7f);
    send_beat(KIND_POLL, 8'sh7f);
    send_beat(KIND_TICK, 8'shff);
    send_beat(KIND_POLL, 8'sh80);
    send_beat(KIND_POLL, 8'sh80);
    send_beat(KIND_POLL, 8'shff);
    send_beat(KIND_POLL, 8'sh80);
    send_beat(KIND_POLL, 8'sh80);
    send_beat(KIND_TICK, 8'sh55);
    send_beat(KIND_POLL, 8'shff);
    send_beat(KIND_POLL, 8'sh01);
    send_beat(KIND_POLL, 8'sh7f);
    send_beat(KIND_TICK, 8'shaa);
    send_beat(KIND_TICK, 8'sh00);

    run_segment(SEND_SLOW, 8'd250, 8'd255, 10'd1023, 4'd2, 4'd1, 350, 8, 1'b0);
    run_segment(SEND_SLOW, 8'd255, 8'd200, 10'd512, 4'd0, 4'd10, 250, 8, 1'b0);
    run_segment(RECV_SLOW, 8'd0, 8'd0, 10'd0, 4'd15, 4'd11, 200, 70, 1'b1);
    run_segment(RECV_SLOW, 8'd1, 8'd255, 10'd1, 4'd10, 4'd0, 200, 70, 1'b1);
    run_segment(NO_GAPS, 8'd240, 8'd255, 10'($urandom), 4'($urandom), 4'($urandom),
                730, 8, 1'b0);

    settle();
    if (mismatch_count == 0 && waiting_beats == 0) begin
      $display("hybrid_dimming_waveform_generator_core_tb passed");
    end else begin
      $display("hybrid_dimming_waveform_generator_core_tb failed");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("hybrid_dimming_waveform_generator_core_tb failed");
    $finish;
  end

endmodule

/* files.f */
+incdir+hdl
hdl/hdwg_pkg.sv
hdl/hdwg_div.sv
hdl/hdwg_win.sv
hdl/hybrid_dimming_waveform_generator_core.sv
hdl/hdwg_chk.sv
bench/hdwg_waveform_check.sv
bench/hybrid_dimming_waveform_generator_core_tb.sv
